// ===== rtl/grd_pkg.sv =====
// shared types and constants of the granular radial distribution pipeline
package grd_pkg;

    // field and register widths
    localparam int VF_W   = 16;   // volume fraction, Q0.16
    localparam int MP_W   = 16;   // maximum packing, Q0.16
    localparam int PC_W   = 14;   // packing coefficient, Q2.12
    localparam int CFG_W  = 16;   // widest register
    localparam int CFG_AW = 1;    // register index
    localparam int RES_W  = 32;   // result words

    // intermediate widths
    localparam int U_W    = 17;   // 1 - a
    localparam int U2_W   = 33;
    localparam int U3_W   = 49;
    localparam int U4_W   = 64;
    localparam int D_W    = 16;   // m - a
    localparam int DD_W   = 32;
    localparam int W_W    = 18;   // 4m - a
    localparam int CA_W   = 30;
    localparam int CAA_W  = 46;
    localparam int CAW_W  = 48;
    localparam int NUM_W  = 18;   // g0 and g0' numerators of the first terms
    localparam int RAD_W  = 48;   // (m - a) * 2^32
    localparam int ROOT_W = 24;
    localparam int DS_W   = 40;
    localparam int DDS_W  = 56;

    localparam int FRONT_STAGES = 3;
    localparam int DEN_STAGES   = 1;
    localparam int DIV_STAGES   = RES_W + 1;

    localparam logic [MP_W-1:0]   MP_RESET      = 16'd41288;
    localparam logic [PC_W-1:0]   PC_RESET      = 14'd9068;
    localparam logic [U_W-1:0]    ONE_Q16       = 17'h10000;
    localparam logic [NUM_W-1:0]  TWO_Q16       = 18'd131072;
    localparam logic [NUM_W-1:0]  FIVE_HALF_Q16 = 18'd163840;

    typedef enum logic [CFG_AW-1:0] {
        REG_MAX_PACKING   = 1'b0,
        REG_PACKING_COEFF = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic at_max;      // fraction at or above packing
        logic zero_frac;   // fraction is zero
    } grd_flags_t;

    typedef struct packed {
        grd_flags_t        flags;
        logic [VF_W-1:0]   a;
        logic [D_W-1:0]    d;
        logic [DD_W-1:0]   dd;
        logic [U3_W-1:0]   u3;
        logic [U4_W-1:0]   u4;
        logic [CAA_W-1:0]  caa;
        logic [CAW_W-1:0]  caw;
    } grd_sq_tag_t;

    typedef struct packed {
        logic              saturated;
        logic [RES_W-1:0]  rdf_slope;
        logic [RES_W-1:0]  rdf_value;
    } grd_result_t;

endpackage

// ===== rtl/grd_pipe_ctrl.sv =====
// valid shift line and two-word output buffer of the pipeline
module grd_pipe_ctrl #(
    parameter int STAGES = 8,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              advance,
    input  logic [DATA_W-1:0] push_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    logic [STAGES-1:0] valid_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic [DATA_W-1:0] buf0_reg;
    logic [DATA_W-1:0] buf1_reg;
    logic              push;
    logic              pop;

    assign advance   = (count_reg != CNT_FULL) | out_ready;
    assign in_ready  = advance;
    assign out_valid = (count_reg != CNT_EMPTY);
    assign out_data  = buf0_reg;
    assign push      = advance & valid_reg[STAGES-1];
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push & ~pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop & ~push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= CNT_EMPTY;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= {valid_reg[STAGES-2:0], in_valid};
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push & pop)
        begin
            if (count_reg == CNT_ONE)
            begin
                buf0_reg <= push_data;
            end
            else
            begin
                buf0_reg <= buf1_reg;
                buf1_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (count_reg == CNT_EMPTY)
            begin
                buf0_reg <= push_data;
            end
            else
            begin
                buf1_reg <= push_data;
            end
        end
        else if (pop)
        begin
            buf0_reg <= buf1_reg;
        end
    end

endmodule

// ===== rtl/grd_isqrt.sv =====
// pipelined integer square root, one root bit per stage
module grd_isqrt #(
    parameter int IN_W  = 48,
    parameter int TAG_W = 1
) (
    input  logic                clk,
    input  logic                en,
    input  logic [IN_W-1:0]     rad,
    input  logic [TAG_W-1:0]    tag_in,
    output logic [IN_W/2-1:0]   root,
    output logic [TAG_W-1:0]    tag_out
);
    import grd_pkg::*;

    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 2;

    logic [RW-1:0]    rem_reg  [0:OUT_W-2];
    logic [IN_W-1:0]  rad_reg  [0:OUT_W-2];
    logic [OUT_W-1:0] root_reg [0:OUT_W-1];
    logic [TAG_W-1:0] tag_reg  [0:OUT_W-1];

    for (genvar k = 0; k < OUT_W; k++)
    begin : g_step
        logic [RW-1:0]    rem_p;
        logic [OUT_W-1:0] root_p;
        logic [IN_W-1:0]  rad_p;
        logic [TAG_W-1:0] tag_p;
        logic [RW-1:0]    rem_sh;
        logic [RW-1:0]    trial;
        logic             take;

        if (k == 0)
        begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign rad_p  = rad;
            assign tag_p  = tag_in;
        end
        else
        begin : g_next
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign rad_p  = rad_reg[k-1];
            assign tag_p  = tag_reg[k-1];
        end

        assign rem_sh = {rem_p[RW-3:0], rad_p[IN_W-1 -: 2]};
        assign trial  = {root_p, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= {root_p[OUT_W-2:0], take};
                tag_reg[k]  <= tag_p;
            end
        end

        if (k < OUT_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? (rem_sh - trial) : rem_sh;
                    rad_reg[k] <= rad_p << 2;
                end
            end
        end
    end

    assign root    = root_reg[OUT_W-1];
    assign tag_out = tag_reg[OUT_W-1];

endmodule

// ===== rtl/grd_div.sv =====
// pipelined saturating divider: floor(num * 2^SHIFT / den), one quotient bit per stage
module grd_div #(
    parameter int NUM_W = 18,
    parameter int SHIFT = 47,
    parameter int DEN_W = 49,
    parameter int TAG_W = 1
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [NUM_W-1:0]            num,
    input  logic [DEN_W-1:0]            den,
    input  logic [TAG_W-1:0]            tag_in,
    output logic [grd_pkg::RES_W-1:0]   quo,
    output logic                        ovf,
    output logic [TAG_W-1:0]            tag_out
);
    import grd_pkg::*;

    localparam int XW   = NUM_W + SHIFT;
    localparam int XH_W = XW - RES_W;
    localparam int CW   = (XH_W > DEN_W) ? XH_W : DEN_W;

    logic [XW-1:0]    x0;
    logic [CW-1:0]    xh_c;
    logic [CW-1:0]    den_c;

    logic [DEN_W-1:0] rem_reg [0:RES_W-1];
    logic [DEN_W-1:0] den_reg [0:RES_W-1];
    logic [RES_W-1:0] xl_reg  [0:RES_W-1];
    logic             ovf_reg [0:RES_W];
    logic [TAG_W-1:0] tag_reg [0:RES_W];
    logic [RES_W-1:0] q_reg   [1:RES_W];

    // upper part against the divisor decides overflow, the low word feeds the bit steps
    assign x0    = XW'(num) << SHIFT;
    assign xh_c  = CW'(x0[XW-1:RES_W]);
    assign den_c = CW'(den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DEN_W'(x0[XW-1:RES_W]);
            den_reg[0] <= den;
            xl_reg[0]  <= x0[RES_W-1:0];
            ovf_reg[0] <= (xh_c >= den_c);
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar j = 1; j <= RES_W; j++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           take;

        assign trial = {rem_reg[j-1], xl_reg[j-1][RES_W-1]};
        assign diff  = trial - {1'b0, den_reg[j-1]};
        assign take  = (trial >= {1'b0, den_reg[j-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ovf_reg[j] <= ovf_reg[j-1];
                tag_reg[j] <= tag_reg[j-1];
            end
        end

        if (j == 1)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[j] <= {{(RES_W-1){1'b0}}, take};
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[j] <= {q_reg[j-1][RES_W-2:0], take};
                end
            end
        end

        if (j < RES_W)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    den_reg[j] <= den_reg[j-1];
                    xl_reg[j]  <= xl_reg[j-1] << 1;
                end
            end
        end
    end

    assign ovf     = ovf_reg[RES_W];
    assign quo     = ovf_reg[RES_W] ? '1 : q_reg[RES_W];
    assign tag_out = tag_reg[RES_W];

endmodule

// ===== rtl/granular_radial_distribution_top.sv =====
// top level of the granular radial distribution pipeline
//
//  channel   dir  handshake             word
//  s_*       in   s_tvalid / s_tready   s_tdata: volume_fraction
//  m_*       out  m_tvalid / m_tready   m_tdata: rdf_value, rdf_slope; m_tuser: saturated
//  cfg_*     in   cfg_we                cfg_addr selects register, cfg_wdata
//
//  one word per clock unless two results wait at the output; from acceptance to m_tvalid
//  a word passes 3 front multiply stages, 24 square root stages, 1 denominator stage,
//  33 divider stages, then the output buffer
//  rst_n clears all valid bits, empties the output buffer and loads the register defaults
//  the pipeline moves as a whole; it halts only while two results wait at the output,
//  so a word is still taken while one finished result is pending
module granular_radial_distribution_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [grd_pkg::VF_W-1:0]       s_tdata,    // [15:0] volume_fraction
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [2*grd_pkg::RES_W-1:0]    m_tdata,    // [31:0] rdf_value, [63:32] rdf_slope
    output logic                           m_tuser,    // [0] saturated
    input  logic                           cfg_we,
    input  logic [grd_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [grd_pkg::CFG_W-1:0]      cfg_wdata
);
    import grd_pkg::*;

    localparam int STAGES = FRONT_STAGES + ROOT_W + DEN_STAGES + DIV_STAGES;
    localparam logic [RES_W-1:0] S1_AT_ZERO = RES_W'(5 * (2 ** (FRAC_BITS - 1)));

    // configuration registers
    logic [MP_W-1:0] mp_reg;
    logic [PC_W-1:0] pc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mp_reg <= MP_RESET;
            pc_reg <= PC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_MAX_PACKING:   mp_reg <= cfg_wdata[MP_W-1:0];
                REG_PACKING_COEFF: pc_reg <= cfg_wdata[PC_W-1:0];
                default:           ;
            endcase
        end
    end

    logic        advance;
    grd_result_t result;
    grd_result_t out_word;

    grd_pipe_ctrl #(
        .STAGES (STAGES),
        .DATA_W ($bits(grd_result_t))
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .advance   (advance),
        .push_data (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign m_tdata = {out_word.rdf_slope, out_word.rdf_value};
    assign m_tuser = out_word.saturated;

    // front stage 0: differences, c*a and (1-a)^2
    logic [U_W-1:0]   u0;
    logic [D_W-1:0]   d0;
    logic [W_W-1:0]   w0;
    logic [CA_W-1:0]  ca0;
    logic [U2_W-1:0]  u20;

    assign u0  = ONE_Q16 - U_W'(s_tdata);
    assign d0  = mp_reg - s_tdata;
    assign w0  = {mp_reg, 2'b00} - W_W'(s_tdata);
    assign ca0 = CA_W'(pc_reg) * CA_W'(s_tdata);
    assign u20 = U2_W'(u0) * U2_W'(u0);

    logic [VF_W-1:0] a_f0_reg;
    logic [U_W-1:0]  u_f0_reg;
    logic [D_W-1:0]  d_f0_reg;
    logic [W_W-1:0]  w_f0_reg;
    logic [CA_W-1:0] ca_f0_reg;
    logic [U2_W-1:0] u2_f0_reg;
    grd_flags_t      flags_f0_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_f0_reg               <= s_tdata;
            u_f0_reg               <= u0;
            d_f0_reg               <= d0;
            w_f0_reg               <= w0;
            ca_f0_reg              <= ca0;
            u2_f0_reg              <= u20;
            flags_f0_reg.at_max    <= (s_tdata >= mp_reg);
            flags_f0_reg.zero_frac <= (s_tdata == '0);
        end
    end

    // front stage 1: (1-a)^3, c*a^2, c*a*(4m-a), (m-a)^2
    logic [VF_W-1:0]  a_f1_reg;
    logic [U_W-1:0]   u_f1_reg;
    logic [D_W-1:0]   d_f1_reg;
    logic [DD_W-1:0]  dd_f1_reg;
    logic [U3_W-1:0]  u3_f1_reg;
    logic [CAA_W-1:0] caa_f1_reg;
    logic [CAW_W-1:0] caw_f1_reg;
    grd_flags_t       flags_f1_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_f1_reg     <= a_f0_reg;
            u_f1_reg     <= u_f0_reg;
            d_f1_reg     <= d_f0_reg;
            dd_f1_reg    <= DD_W'(d_f0_reg) * DD_W'(d_f0_reg);
            u3_f1_reg    <= U3_W'(u2_f0_reg) * U3_W'(u_f0_reg);
            caa_f1_reg   <= CAA_W'(ca_f0_reg) * CAA_W'(a_f0_reg);
            caw_f1_reg   <= CAW_W'(ca_f0_reg) * CAW_W'(w_f0_reg);
            flags_f1_reg <= flags_f0_reg;
        end
    end

    // front stage 2: (1-a)^4, low 64 bits (only a zero fraction needs bit 64, handled later)
    grd_sq_tag_t sq_tag_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_tag_reg.flags <= flags_f1_reg;
            sq_tag_reg.a     <= a_f1_reg;
            sq_tag_reg.d     <= d_f1_reg;
            sq_tag_reg.dd    <= dd_f1_reg;
            sq_tag_reg.u3    <= u3_f1_reg;
            sq_tag_reg.u4    <= U4_W'(u3_f1_reg) * U4_W'(u_f1_reg);
            sq_tag_reg.caa   <= caa_f1_reg;
            sq_tag_reg.caw   <= caw_f1_reg;
        end
    end

    // sqrt(m-a) scaled by 2^24
    logic [ROOT_W-1:0] root;
    grd_sq_tag_t       sq_out;

    grd_isqrt #(
        .IN_W  (RAD_W),
        .TAG_W ($bits(grd_sq_tag_t))
    ) u_isqrt (
        .clk     (clk),
        .en      (advance),
        .rad     ({sq_tag_reg.d, (RAD_W - D_W)'(0)}),
        .tag_in  (sq_tag_reg),
        .root    (root),
        .tag_out (sq_out)
    );

    // denominator stage for the c terms, numerators of the first terms
    grd_flags_t       flags_dn_reg;
    logic [NUM_W-1:0] n1_reg;
    logic [NUM_W-1:0] n3_reg;
    logic [CAA_W-1:0] caa_reg;
    logic [CAW_W-1:0] caw_reg;
    logic [U3_W-1:0]  u3_reg;
    logic [U4_W-1:0]  u4_reg;
    logic [DS_W-1:0]  ds_reg;
    logic [DDS_W-1:0] dds_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            flags_dn_reg <= sq_out.flags;
            n1_reg       <= TWO_Q16 - NUM_W'(sq_out.a);
            n3_reg       <= FIVE_HALF_Q16 - NUM_W'(sq_out.a);
            caa_reg      <= sq_out.caa;
            caw_reg      <= sq_out.caw;
            u3_reg       <= sq_out.u3;
            u4_reg       <= sq_out.u4;
            ds_reg       <= DS_W'(sq_out.d) * DS_W'(root);
            dds_reg      <= DDS_W'(sq_out.dd) * DDS_W'(root);
        end
    end

    // four dividers in lockstep; the first carries the flags
    logic [RES_W-1:0] q_v1;
    logic [RES_W-1:0] q_v2;
    logic [RES_W-1:0] q_s1;
    logic [RES_W-1:0] q_s2;
    logic             o_v1;
    logic             o_v2;
    logic             o_s1;
    logic             o_s2;
    grd_flags_t       flags_out;

    grd_div #(
        .NUM_W (NUM_W),
        .SHIFT (31 + FRAC_BITS),
        .DEN_W (U3_W),
        .TAG_W ($bits(grd_flags_t))
    ) u_div_v1 (
        .clk     (clk),
        .en      (advance),
        .num     (n1_reg),
        .den     (u3_reg),
        .tag_in  (flags_dn_reg),
        .quo     (q_v1),
        .ovf     (o_v1),
        .tag_out (flags_out)
    );

    grd_div #(
        .NUM_W (CAA_W),
        .SHIFT (FRAC_BITS - 4),
        .DEN_W (DS_W),
        .TAG_W (1)
    ) u_div_v2 (
        .clk     (clk),
        .en      (advance),
        .num     (caa_reg),
        .den     (ds_reg),
        .tag_in  (1'b0),
        .quo     (q_v2),
        .ovf     (o_v2),
        .tag_out ()
    );

    grd_div #(
        .NUM_W (NUM_W),
        .SHIFT (48 + FRAC_BITS),
        .DEN_W (U4_W),
        .TAG_W (1)
    ) u_div_s1 (
        .clk     (clk),
        .en      (advance),
        .num     (n3_reg),
        .den     (u4_reg),
        .tag_in  (1'b0),
        .quo     (q_s1),
        .ovf     (o_s1),
        .tag_out ()
    );

    grd_div #(
        .NUM_W (CAW_W),
        .SHIFT (11 + FRAC_BITS),
        .DEN_W (DDS_W),
        .TAG_W (1)
    ) u_div_s2 (
        .clk     (clk),
        .en      (advance),
        .num     (caw_reg),
        .den     (dds_reg),
        .tag_in  (1'b0),
        .quo     (q_s2),
        .ovf     (o_s2),
        .tag_out ()
    );

    // sums with saturation; a zero fraction takes the exact slope constant
    logic [RES_W:0]   sum_v;
    logic [RES_W:0]   sum_s;
    logic [RES_W-1:0] s1_term;
    logic             s1_ovf;

    assign s1_term = flags_out.zero_frac ? S1_AT_ZERO : q_s1;
    assign s1_ovf  = o_s1 & ~flags_out.zero_frac;
    assign sum_v   = {1'b0, q_v1} + {1'b0, q_v2};
    assign sum_s   = {1'b0, s1_term} + {1'b0, q_s2};

    always_comb
    begin
        result.saturated = flags_out.at_max | o_v1 | o_v2 | s1_ovf | o_s2
                         | sum_v[RES_W] | sum_s[RES_W];
        if (flags_out.at_max | sum_v[RES_W])
        begin
            result.rdf_value = '1;
        end
        else
        begin
            result.rdf_value = sum_v[RES_W-1:0];
        end
        if (flags_out.at_max | sum_s[RES_W])
        begin
            result.rdf_slope = '1;
        end
        else
        begin
            result.rdf_slope = sum_s[RES_W-1:0];
        end
    end

endmodule
